/* design/mctw_pkg.sv */
// Shared types and constants for the three-wire memory card bus master.
package mctw_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  localparam logic [7:0] POLL_LIMIT_RST = 8'd250;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] control_code;
    logic [9:0] address;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic       with_protect;
    logic       io_in;
  } req_t;

  typedef struct packed {
    logic       clk_out;
    logic       rst_out;
    logic       io_out;
    logic       io_drive;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       protect_bit;
    logic       last;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } res_t;

endpackage

/* design/memory_card_three_wire_bus_master.sv */
// Tick-driven master for a three-wire memory card bus: sequencer and result buffer.
// Each request is one half period of the card clock; its result is registered in
// the output register, or in the skid while that is full. A request can be accepted
// every cycle while the skid is empty; a two-entry result buffer (output register
// plus skid) keeps input flowing while one result waits. Asynchronous active-low
// reset idles the sequencer, clears the result buffer, sets the poll limit to 250.
module memory_card_three_wire_bus_master (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mctw_pkg::req_t      in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mctw_pkg::res_t      out_res_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_PRE    = 4'd1;
  localparam logic [3:0] PH_SLOW   = 4'd2;
  localparam logic [3:0] PH_SHIGH  = 4'd3;
  localparam logic [3:0] PH_ELOW   = 4'd4;
  localparam logic [3:0] PH_EHIGH  = 4'd5;
  localparam logic [3:0] PH_RLOW   = 4'd6;
  localparam logic [3:0] PH_RHIGH  = 4'd7;
  localparam logic [3:0] PH_PWAIT  = 4'd8;
  localparam logic [3:0] PH_PHIGH  = 4'd9;
  localparam logic [3:0] PH_PCHECK = 4'd10;
  localparam logic [3:0] PH_FINISH = 4'd11;

  localparam logic [4:0] CMD_BITS   = 5'd24;
  localparam logic [4:0] DATA_BITS  = 5'd8;
  localparam logic [4:0] PROT_BITS  = 5'd9;
  localparam logic [7:0] POLL_SAT   = 8'd255;

  logic [7:0]  poll_limit_q;
  logic [3:0]  phase_q, phase_d;
  logic [23:0] cmd_shift_q, cmd_shift_d;
  logic [4:0]  bit_cnt_q, bit_cnt_d;
  logic [8:0]  rd_shift_q, rd_shift_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [7:0]  poll_cnt_q, poll_cnt_d;
  logic [1:0]  mode_q, mode_d;   // bit0 write, bit1 protect

  mctw_pkg::res_t res_d;
  mctw_pkg::res_t head_q, skid_q;
  logic           head_v_q, skid_v_q;

  logic       accept, pop;
  logic [7:0] lim;
  logic [4:0] nbits;

  assign accept     = in_valid_i && !skid_v_q;
  assign pop        = head_v_q && !out_stall_i;
  assign in_stall_o = skid_v_q;
  assign out_valid_o = head_v_q;
  assign out_res_o  = head_q;

  assign lim   = (poll_limit_q == 8'd0) ? 8'd1 : poll_limit_q;
  assign nbits = mode_q[1] ? PROT_BITS : DATA_BITS;

  always_comb begin
    phase_d      = phase_q;
    cmd_shift_d  = cmd_shift_q;
    bit_cnt_d    = bit_cnt_q;
    rd_shift_d   = rd_shift_q;
    bytes_left_d = bytes_left_q;
    poll_cnt_d   = poll_cnt_q;
    mode_d       = mode_q;
    res_d        = '0;
    case (phase_q)
      PH_IDLE: begin
        if (in_req_i.cmd == mctw_pkg::CMD_READ || in_req_i.cmd == mctw_pkg::CMD_WRITE) begin
          cmd_shift_d  = {in_req_i.write_data, in_req_i.address[7:0],
                          in_req_i.address[9:8], in_req_i.control_code};
          bytes_left_d = in_req_i.byte_count;
          mode_d       = {in_req_i.with_protect, in_req_i.cmd == mctw_pkg::CMD_WRITE};
          bit_cnt_d    = '0;
          rd_shift_d   = '0;
          poll_cnt_d   = '0;
          res_d.clk_out = 1'b1;
          phase_d      = PH_PRE;
        end
      end
      PH_PRE: begin
        bit_cnt_d = '0;
        phase_d   = PH_SLOW;
      end
      PH_SLOW: begin
        res_d.rst_out  = 1'b1;
        res_d.io_drive = 1'b1;
        res_d.io_out   = cmd_shift_q[0];
        phase_d        = PH_SHIGH;
      end
      PH_SHIGH: begin
        res_d.rst_out  = 1'b1;
        res_d.io_drive = 1'b1;
        res_d.io_out   = cmd_shift_q[0];
        res_d.clk_out  = 1'b1;
        cmd_shift_d    = {1'b0, cmd_shift_q[23:1]};
        bit_cnt_d      = bit_cnt_q + 5'd1;
        phase_d        = (bit_cnt_d >= CMD_BITS) ? PH_ELOW : PH_SLOW;
      end
      PH_ELOW: phase_d = PH_EHIGH;
      PH_EHIGH: begin
        res_d.clk_out = 1'b1;
        bit_cnt_d     = '0;
        rd_shift_d    = '0;
        poll_cnt_d    = '0;
        if (mode_q[0]) begin
          phase_d = PH_PWAIT;
        end else begin
          phase_d = (bytes_left_q == 8'd0) ? PH_FINISH : PH_RLOW;
        end
      end
      PH_RLOW: phase_d = PH_RHIGH;
      PH_RHIGH: begin
        res_d.clk_out = 1'b1;
        // data bits enter at bit 7 and move down; the protect bit lands at bit 8
        if (bit_cnt_q < DATA_BITS) begin
          rd_shift_d = {1'b0, in_req_i.io_in, rd_shift_q[7:1]};
        end else begin
          rd_shift_d = {in_req_i.io_in | rd_shift_q[8], rd_shift_q[7:0]};
        end
        bit_cnt_d = bit_cnt_q + 5'd1;
        phase_d   = PH_RLOW;
        if (bit_cnt_d >= nbits) begin
          res_d.byte_valid  = 1'b1;
          res_d.read_byte   = rd_shift_d[7:0];
          res_d.protect_bit = rd_shift_d[8];
          bytes_left_d      = bytes_left_q - 8'd1;
          res_d.last        = (bytes_left_d == 8'd0);
          bit_cnt_d         = '0;
          rd_shift_d        = '0;
          if (bytes_left_d == 8'd0) phase_d = PH_FINISH;
        end
      end
      PH_FINISH: begin
        res_d.done_res = 1'b1;
        phase_d        = PH_IDLE;
      end
      PH_PWAIT: phase_d = PH_PHIGH;
      PH_PHIGH: begin
        res_d.clk_out = 1'b1;
        if (poll_cnt_q < POLL_SAT) poll_cnt_d = poll_cnt_q + 8'd1;
        phase_d = PH_PCHECK;
      end
      PH_PCHECK: begin
        if (!in_req_i.io_in) begin
          res_d.done_res = 1'b1;
          phase_d        = PH_IDLE;
        end else if (poll_cnt_q >= lim) begin
          res_d.done_res = 1'b1;
          res_d.status   = 1'b1;
          phase_d        = PH_IDLE;
        end else begin
          phase_d = PH_PHIGH;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    res_d.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= mctw_pkg::POLL_LIMIT_RST;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cmd_shift_q  <= '0;
      bit_cnt_q    <= '0;
      rd_shift_q   <= '0;
      bytes_left_q <= '0;
      poll_cnt_q   <= '0;
      mode_q       <= '0;
    end else if (accept) begin
      phase_q      <= phase_d;
      cmd_shift_q  <= cmd_shift_d;
      bit_cnt_q    <= bit_cnt_d;
      rd_shift_q   <= rd_shift_d;
      bytes_left_q <= bytes_left_d;
      poll_cnt_q   <= poll_cnt_d;
      mode_q       <= mode_d;
    end
  end

  // result buffer: head is the output register, skid takes a result while head waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!head_v_q) begin
        head_v_q <= accept;
      end else if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= accept;
        end else begin
          head_v_q <= accept;
        end
      end else if (accept) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_v_q) begin
      if (accept) head_q <= res_d;
    end else if (pop) begin
      if (skid_v_q) begin
        head_q <= skid_q;
        if (accept) skid_q <= res_d;
      end else if (accept) begin
        head_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q)
    else $error("skid entry held without head entry");

  a_io_only_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_v_q && head_q.io_out) |-> head_q.io_drive)
    else $error("io_out high while line not driven");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_v_q && head_q.done_res) |-> !head_q.busy_res)
    else $error("operation done but still busy");

  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_v_q && head_q.status) |-> head_q.done_res)
    else $error("timeout status without done");

  a_last_with_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_v_q && head_q.last) |-> head_q.byte_valid)
    else $error("last mark without a read byte");

endmodule
